// File: design/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg: shared definitions for the letter filter and sort block
// Widths, ASCII constants and the sequencer state type used by the design.
// ----------------------------------------------------------------------------
package lfs_pkg;

   localparam int CODE_W      = 8;
   localparam int LETTER_W    = 7;
   localparam int ALPHABET    = 26;
   localparam int IDX_W       = $clog2(ALPHABET);
   localparam int MAX_LEN_DEF = 64;

   localparam logic [CODE_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CODE_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [CODE_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CODE_W-1:0] ASCII_LOWER_Z = 8'h7A;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_ACCUM = 6'b000001,
      ST_DRAIN = 6'b000010,
      ST_READ  = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_EMPTY = 6'b100000
   } state_type;

endpackage

// File: design/lfs_req_if.sv
// ----------------------------------------------------------------------------
// lfs_req_if: input byte channel
// Carries one byte of a string per item, with its end-of-string mark.
// ----------------------------------------------------------------------------
interface lfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [lfs_pkg::CODE_W-1:0]    char_code;
   logic                          end_of_string;

   modport source (output valid, output char_code, output end_of_string, input ready);
   modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

// File: design/lfs_rsp_if.sv
// ----------------------------------------------------------------------------
// lfs_rsp_if: sorted letter channel
// Carries one sorted letter per item, with final, empty and overflow flags.
// ----------------------------------------------------------------------------
interface lfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lfs_pkg::LETTER_W-1:0]  letter;
   logic                          final_letter;
   logic                          empty_result;
   logic                          overflow;

   modport source (output valid, output letter, output final_letter,
                   output empty_result, output overflow, input ready);
   modport sink   (input valid, input letter, input final_letter,
                   input empty_result, input overflow, output ready);
endinterface

// File: design/lfs_ram.sv
// ----------------------------------------------------------------------------
// lfs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/letter_filter_sort.sv
// ----------------------------------------------------------------------------
// letter_filter_sort: counting sort of the letters of a byte string
// Keeps ASCII letters folded to lower case and returns them sorted.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one byte of a string per item; end_of_string marks
// the last byte. Letters are counted in a 26-entry RAM by a read-modify-write
// pipeline with forwarding, so while a string streams in the block takes one
// item per cycle. Non-letters are ignored; letters beyond MAX_LEN are dropped
// and the whole run is flagged overflow.
// After the last byte the block stops taking items and walks the count RAM:
// a drain state lets the pipeline finish, then each letter entry visited is
// read and loaded and each of its results emitted, each entry being zeroed as
// it is read. A string without letters gives one item with empty_result set.
// The rsp channel is fed from an output register: while it holds an item the
// receiver has not taken, the walk waits, and new bytes are still taken once
// the walk is over. Reset is synchronous: counts read as zero through
// per-entry valid bits, totals and flags clear, and the output goes idle.
// ----------------------------------------------------------------------------
module letter_filter_sort #(
   parameter int MAX_LEN = lfs_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lfs_req_if.sink   req_ch,
   lfs_rsp_if.source rsp_ch
);

   // Counters hold values up to MAX_LEN.
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   lfs_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] kept_ff, kept_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] emitted_ff, emitted_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [lfs_pkg::IDX_W-1:0] idx_ff, idx_in;

   // Increment stage of the read-modify-write pipeline.
   logic                      s1_valid_ff;
   logic [lfs_pkg::IDX_W-1:0] s1_addr_ff;

   // Last increment written, forwarded to a read of the same entry.
   logic                      fwd_valid_ff;
   logic [lfs_pkg::IDX_W-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]          fwd_data_ff;

   // An entry that was never written since reset reads as zero.
   logic [lfs_pkg::ALPHABET-1:0] entry_valid_ff;
   logic                         rd_valid_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic [lfs_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                         final_ff, final_in;
   logic                         empty_ff, empty_in;
   logic                         ovf_ff, ovf_in;
   logic                         rsp_load;

   logic                      req_fire;
   logic                      is_upper, is_lower, is_letter, room;
   logic [lfs_pkg::IDX_W-1:0] slot;
   logic                      count_it;

   logic                      ram_we;
   logic [lfs_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
   logic [CNT_W-1:0]          ram_wdata, ram_rdata, count_rd, base, inc_value;
   logic                      out_free;
   logic                      last_one;

   lfs_ram #(
      .WIDTH (CNT_W),
      .DEPTH (lfs_pkg::ALPHABET)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Input side: only the accumulate state takes bytes.
   assign req_ch.ready = (state_ff == lfs_pkg::ST_ACCUM);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign is_upper  = (req_ch.char_code >= lfs_pkg::ASCII_UPPER_A) &&
                      (req_ch.char_code <= lfs_pkg::ASCII_UPPER_Z);
   assign is_lower  = (req_ch.char_code >= lfs_pkg::ASCII_LOWER_A) &&
                      (req_ch.char_code <= lfs_pkg::ASCII_LOWER_Z);
   assign is_letter = is_upper || is_lower;
   assign slot      = is_upper ?
                      lfs_pkg::IDX_W'(req_ch.char_code - lfs_pkg::ASCII_UPPER_A) :
                      lfs_pkg::IDX_W'(req_ch.char_code - lfs_pkg::ASCII_LOWER_A);
   assign room      = (kept_ff < CNT_W'(MAX_LEN));
   assign count_it  = req_fire && is_letter && room;

   // The read address follows the incoming letter while accumulating and the
   // walk index otherwise.
   assign ram_raddr = (state_ff == lfs_pkg::ST_ACCUM) ? slot : idx_ff;
   assign count_rd  = rd_valid_ff ? ram_rdata : '0;

   // The read of an entry sees the old value when the previous item wrote the
   // same entry in the same cycle, so that write is forwarded here.
   assign base      = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff
                                                                     : count_rd;
   assign inc_value = base + CNT_W'(1);

   // One write port: pending increments, or zeroing each entry as it is read.
   assign ram_we    = s1_valid_ff || (state_ff == lfs_pkg::ST_READ);
   assign ram_waddr = s1_valid_ff ? s1_addr_ff : idx_ff;
   assign ram_wdata = s1_valid_ff ? inc_value : '0;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign last_one  = ((emitted_ff + CNT_W'(1)) == kept_ff);

   always_comb begin
      state_in   = state_ff;
      kept_in    = kept_ff;
      dropped_in = dropped_ff;
      emitted_in = emitted_ff;
      remain_in  = remain_ff;
      idx_in     = idx_ff;
      rsp_load   = 1'b0;
      letter_in  = '0;
      final_in   = 1'b0;
      empty_in   = 1'b0;
      ovf_in     = dropped_ff;

      case (state_ff)
         lfs_pkg::ST_ACCUM: begin
            if (count_it) begin
               kept_in = kept_ff + CNT_W'(1);
            end
            if (req_fire && is_letter && !room) begin
               dropped_in = 1'b1;
            end
            if (req_fire && req_ch.end_of_string) begin
               state_in = lfs_pkg::ST_DRAIN;
            end
         end
         lfs_pkg::ST_DRAIN: begin
            // The last increment is written during this cycle.
            idx_in   = '0;
            state_in = (kept_ff == '0) ? lfs_pkg::ST_EMPTY : lfs_pkg::ST_READ;
         end
         lfs_pkg::ST_READ: begin
            state_in = lfs_pkg::ST_LOAD;
         end
         lfs_pkg::ST_LOAD: begin
            remain_in = count_rd;
            if (count_rd == '0) begin
               idx_in   = idx_ff + lfs_pkg::IDX_W'(1);
               state_in = lfs_pkg::ST_READ;
            end else begin
               state_in = lfs_pkg::ST_EMIT;
            end
         end
         lfs_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               letter_in  = lfs_pkg::LETTER_W'(lfs_pkg::ASCII_LOWER_A) +
                            lfs_pkg::LETTER_W'(idx_ff);
               final_in   = last_one;
               emitted_in = emitted_ff + CNT_W'(1);
               remain_in  = remain_ff - CNT_W'(1);
               if (last_one) begin
                  kept_in    = '0;
                  dropped_in = 1'b0;
                  emitted_in = '0;
                  state_in   = lfs_pkg::ST_ACCUM;
               end else if (remain_ff == CNT_W'(1)) begin
                  idx_in   = idx_ff + lfs_pkg::IDX_W'(1);
                  state_in = lfs_pkg::ST_READ;
               end
            end
         end
         lfs_pkg::ST_EMPTY: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               final_in   = 1'b1;
               empty_in   = 1'b1;
               kept_in    = '0;
               dropped_in = 1'b0;
               emitted_in = '0;
               state_in   = lfs_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = lfs_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lfs_pkg::ST_ACCUM;
         kept_ff        <= '0;
         dropped_ff     <= 1'b0;
         emitted_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         dropped_ff   <= dropped_in;
         emitted_ff   <= emitted_in;
         s1_valid_ff  <= count_it;
         fwd_valid_ff <= s1_valid_ff;
         if (ram_we) begin
            entry_valid_ff[ram_waddr] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and datapath registers need no reset.
   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      idx_ff      <= idx_in;
      s1_addr_ff  <= slot;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= inc_value;
      rd_valid_ff <= entry_valid_ff[ram_raddr];
      if (rsp_load) begin
         letter_ff <= letter_in;
         final_ff  <= final_in;
         empty_ff  <= empty_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.letter       = letter_ff;
   assign rsp_ch.final_letter = final_ff;
   assign rsp_ch.empty_result = empty_ff;
   assign rsp_ch.overflow     = ovf_ff;

   // The number of kept letters never passes the capacity.
   a_kept_bound : assert property (@(posedge clock) disable iff (reset)
      kept_ff <= CNT_W'(MAX_LEN))
      else $error("kept letter total exceeds capacity");

   // The walk never emits more letters than were kept.
   a_emit_bound : assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= kept_ff)
      else $error("more letters emitted than kept");

   // The end of a string closes the input until its results are produced.
   a_eos_stall : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.end_of_string |=> !req_ch.ready)
      else $error("input taken right after end of string");

   // An empty result is always the final one and carries the zero letter.
   a_empty_final : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.empty_result |-> rsp_ch.final_letter &&
      (rsp_ch.letter == '0))
      else $error("empty result not marked final");

endmodule
